/* hdl/dvrc_pkg.sv */
package dvrc_pkg;

    // Line status codes reported at each end of line
    typedef enum logic [3:0] {
        ST_REC_OK   = 4'd0,
        ST_HDR_OK   = 4'd1,
        ST_HDR_BAD  = 4'd2,
        ST_LENGTH   = 4'd3,
        ST_DATE_FMT = 4'd4,
        ST_SEP      = 4'd5,
        ST_VALUE    = 4'd6,
        ST_MONTH    = 4'd7,
        ST_DAY      = 4'd8,
        ST_NEGATIVE = 4'd9,
        ST_HALTED   = 4'd10
    } t_status;

    // Character codes
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Expected first line: the date and rate column titles
    localparam int HDR_LEN = 18;
    localparam logic [7:0] HDR_TEXT [0:HDR_LEN-1] = '{
        8'h64, 8'h61, 8'h74, 8'h65, 8'h2C, 8'h65, 8'h78, 8'h63, 8'h68,
        8'h61, 8'h6E, 8'h67, 8'h65, 8'h5F, 8'h72, 8'h61, 8'h74, 8'h65
    };

    // First value column and minimum data line length
    localparam int VAL_START = 11;
    localparam int MIN_LEN   = 12;

    // Header character at a position, zero past the end
    function automatic logic [7:0] hdr_char(input logic [4:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (idx < 5'(HDR_LEN)) begin
            c = HDR_TEXT[idx];
        end
        return c;
    endfunction

endpackage

/* hdl/dated_value_record_checker.sv */
// Dated value record checker.
// Input channel: i_valid / o_stall with one character (i_ch) or an end of
// line marker (i_end_of_line) per transfer. A character transfer gives no
// result; an end of line transfer gives exactly one result transfer on
// o_valid / i_stall carrying status, error column, line number and date key.
// The first line must be the header; later lines are YYYY-MM-DD,value.
// After the first failing line every later line reports halted.
// Throughput: one input transfer per cycle while o_stall is low. Each
// transfer lands in an input register and is checked by one pass of logic
// into the line state and the result register, from which an end of line
// result is visible.
// A stall on the result side holds the result register; the input side
// keeps taking characters and only stalls when an end of line reaches
// the checker while the held result has not yet been taken.
// Reset (synchronous, active low) empties both registers, zeroes the line
// counter and clears the halted state and all per-line state.
module dated_value_record_checker #(
    parameter int COLUMN_BITS     = 11,
    parameter int LINE_COUNT_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    input  logic        i_end_of_line,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_status,
    output logic [10:0] o_column,
    output logic [23:0] o_line_number,
    output logic [26:0] o_date_key
);
    import dvrc_pkg::*;

    localparam logic [COLUMN_BITS-1:0]     COL_MAX  = {COLUMN_BITS{1'b1}};
    localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = {LINE_COUNT_BITS{1'b1}};

    // Input register
    logic       r_in_valid;
    logic [7:0] r_ch;
    logic       r_eol;

    // Line state
    logic [LINE_COUNT_BITS-1:0] r_line_count, n_line_count;
    logic [COLUMN_BITS-1:0]     r_position, n_position;
    logic [6:0]                 r_year_hi, n_year_hi;
    logic [6:0]                 r_year_lo, n_year_lo;
    logic [6:0]                 r_month, n_month;
    logic [6:0]                 r_day, n_day;
    t_status                    r_first_error, n_first_error;
    logic [COLUMN_BITS-1:0]     r_err_col, n_err_col;
    logic                       r_f_dot, n_f_dot;
    logic                       r_f_digit, n_f_digit;
    logic                       r_f_minus, n_f_minus;
    logic                       r_f_nonzero, n_f_nonzero;
    logic                       r_header_match, n_header_match;
    logic                       r_halted, n_halted;

    // Result register
    logic        r_out_valid;
    t_status     r_status;
    logic [10:0] r_column;
    logic [23:0] r_line_number;
    logic [26:0] r_date_key;

    // Line end evaluation
    t_status                    e_status;
    logic [COLUMN_BITS-1:0]     e_col;
    logic [26:0]                e_key;
    logic [COLUMN_BITS+10:0]    col_ext;
    logic [LINE_COUNT_BITS+23:0] line_ext;

    logic       out_free;
    logic       proc_go;
    logic       in_ready;
    logic       load_out;
    logic       is_hdr;
    logic       is_dig;
    logic [3:0] dig;
    logic [COLUMN_BITS-1:0] p;
    logic       leap;
    logic [4:0] dim;

    // Handshake: the checker advances unless an end of line meets a held result
    assign out_free = !r_out_valid || !i_stall;
    assign proc_go  = r_in_valid && (!r_eol || out_free);
    assign in_ready = !r_in_valid || proc_go;
    assign load_out = proc_go && r_eol;
    assign o_stall  = !in_ready;

    assign is_hdr = (r_line_count == '0);
    assign p      = r_position;
    assign is_dig = (r_ch >= CH_ZERO) && (r_ch <= CH_NINE);
    assign dig    = r_ch[3:0];

    // 1-based column of a position, saturating
    function automatic logic [COLUMN_BITS-1:0] col_of(input logic [COLUMN_BITS-1:0] pos);
        logic [COLUMN_BITS-1:0] c;
        c = (pos == COL_MAX) ? COL_MAX : pos + 1'b1;
        return c;
    endfunction

    // Days in month with Gregorian leap years (year = hi*100 + lo)
    always_comb begin
        leap = ((r_year_lo[1:0] == 2'd0) && (r_year_lo != 7'd0))
            || ((r_year_lo == 7'd0) && (r_year_hi[1:0] == 2'd0));
        if (r_month == 7'd2) begin
            dim = leap ? 5'd29 : 5'd28;
        end else if (r_month == 7'd4 || r_month == 7'd6 || r_month == 7'd9
                     || r_month == 7'd11) begin
            dim = 5'd30;
        end else begin
            dim = 5'd31;
        end
    end

    // Status, column and key at end of line
    always_comb begin
        e_status = ST_REC_OK;
        e_col    = '0;
        e_key    = '0;
        priority if (r_halted) begin
            e_status = ST_HALTED;
        end else if (is_hdr) begin
            e_status = (r_header_match && r_position == COLUMN_BITS'(HDR_LEN))
                     ? ST_HDR_OK : ST_HDR_BAD;
        end else if (r_position < COLUMN_BITS'(MIN_LEN)) begin
            e_status = ST_LENGTH;
            e_col    = r_position;
        end else if (r_first_error != ST_REC_OK) begin
            e_status = r_first_error;
            e_col    = r_err_col;
        end else if (!r_f_digit) begin
            e_status = ST_VALUE;
            e_col    = COLUMN_BITS'(12);
        end else if (r_month == 7'd0 || r_month > 7'd12) begin
            e_status = ST_MONTH;
            e_col    = COLUMN_BITS'(6);
        end else if (r_day == 7'd0 || r_day > {2'b00, dim}) begin
            e_status = ST_DAY;
            e_col    = COLUMN_BITS'(9);
        end else if (r_f_minus && r_f_nonzero) begin
            e_status = ST_NEGATIVE;
            e_col    = COLUMN_BITS'(12);
        end else begin
            e_key = 27'(r_year_hi) * 27'd1000000 + 27'(r_year_lo) * 27'd10000
                  + 27'(r_month) * 27'd100 + 27'(r_day);
        end
    end

    assign col_ext  = {11'd0, e_col};
    assign line_ext = {24'd0, n_line_count};

    // Next line state for one character or end of line
    always_comb begin
        n_line_count   = r_line_count;
        n_position     = r_position;
        n_year_hi      = r_year_hi;
        n_year_lo      = r_year_lo;
        n_month        = r_month;
        n_day          = r_day;
        n_first_error  = r_first_error;
        n_err_col      = r_err_col;
        n_f_dot        = r_f_dot;
        n_f_digit      = r_f_digit;
        n_f_minus      = r_f_minus;
        n_f_nonzero    = r_f_nonzero;
        n_header_match = r_header_match;
        n_halted       = r_halted;
        if (!r_eol) begin
            if (!r_halted) begin
                if (is_hdr) begin
                    if (p >= COLUMN_BITS'(HDR_LEN) || hdr_char(p[4:0]) != r_ch) begin
                        n_header_match = 1'b0;
                    end
                end else if (r_first_error == ST_REC_OK) begin
                    if (p < COLUMN_BITS'(10)) begin
                        // date field
                        if (p == COLUMN_BITS'(4) || p == COLUMN_BITS'(7)) begin
                            if (r_ch != CH_DASH) begin
                                n_first_error = ST_DATE_FMT;
                                n_err_col     = p + 1'b1;
                            end
                        end else if (!is_dig) begin
                            n_first_error = ST_DATE_FMT;
                            n_err_col     = p + 1'b1;
                        end else if (p < COLUMN_BITS'(2)) begin
                            n_year_hi = 7'(r_year_hi * 7'd10 + 7'(dig));
                        end else if (p < COLUMN_BITS'(4)) begin
                            n_year_lo = 7'(r_year_lo * 7'd10 + 7'(dig));
                        end else if (p < COLUMN_BITS'(7)) begin
                            n_month = 7'(r_month * 7'd10 + 7'(dig));
                        end else begin
                            n_day = 7'(r_day * 7'd10 + 7'(dig));
                        end
                    end else if (p == COLUMN_BITS'(10)) begin
                        if (r_ch != CH_COMMA) begin
                            n_first_error = ST_SEP;
                            n_err_col     = COLUMN_BITS'(11);
                        end
                    end else if (p == COLUMN_BITS'(VAL_START)
                                 && (r_ch == CH_PLUS || r_ch == CH_DASH)) begin
                        // leading sign
                        if (r_ch == CH_DASH) begin
                            n_f_minus = 1'b1;
                        end
                    end else if (r_ch == CH_DOT) begin
                        if (r_f_dot) begin
                            n_first_error = ST_VALUE;
                            n_err_col     = col_of(p);
                        end
                        n_f_dot = 1'b1;
                    end else if (is_dig) begin
                        n_f_digit = 1'b1;
                        if (r_ch != CH_ZERO) begin
                            n_f_nonzero = 1'b1;
                        end
                    end else begin
                        n_first_error = ST_VALUE;
                        n_err_col     = col_of(p);
                    end
                end
                if (p != COL_MAX) begin
                    n_position = p + 1'b1;
                end
            end
        end else begin
            // line end: count, latch halt, start a new line
            if (r_line_count != LINE_MAX) begin
                n_line_count = r_line_count + 1'b1;
            end
            if (e_status != ST_REC_OK && e_status != ST_HDR_OK) begin
                n_halted = 1'b1;
            end
            n_position     = '0;
            n_year_hi      = '0;
            n_year_lo      = '0;
            n_month        = '0;
            n_day          = '0;
            n_first_error  = ST_REC_OK;
            n_err_col      = '0;
            n_f_dot        = 1'b0;
            n_f_digit      = 1'b0;
            n_f_minus      = 1'b0;
            n_f_nonzero    = 1'b0;
            n_header_match = 1'b1;
        end
    end

    // Control and line state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_line_count   <= '0;
            r_position     <= '0;
            r_year_hi      <= '0;
            r_year_lo      <= '0;
            r_month        <= '0;
            r_day          <= '0;
            r_first_error  <= ST_REC_OK;
            r_err_col      <= '0;
            r_f_dot        <= 1'b0;
            r_f_digit      <= 1'b0;
            r_f_minus      <= 1'b0;
            r_f_nonzero    <= 1'b0;
            r_header_match <= 1'b1;
            r_halted       <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_valid <= i_valid;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (proc_go) begin
                r_line_count   <= n_line_count;
                r_position     <= n_position;
                r_year_hi      <= n_year_hi;
                r_year_lo      <= n_year_lo;
                r_month        <= n_month;
                r_day          <= n_day;
                r_first_error  <= n_first_error;
                r_err_col      <= n_err_col;
                r_f_dot        <= n_f_dot;
                r_f_digit      <= n_f_digit;
                r_f_minus      <= n_f_minus;
                r_f_nonzero    <= n_f_nonzero;
                r_header_match <= n_header_match;
                r_halted       <= n_halted;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_valid && in_ready) begin
            r_ch  <= i_ch;
            r_eol <= i_end_of_line;
        end
        if (load_out) begin
            r_status      <= e_status;
            r_column      <= col_ext[10:0];
            r_line_number <= line_ext[23:0];
            r_date_key    <= e_key;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_column      = r_column;
    assign o_line_number = r_line_number;
    assign o_date_key    = r_date_key;

    // Once halted, the block stays halted until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted state cleared without reset");

    // A line ended while halted reports halted
    a_halt_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out && r_halted |=> o_valid && o_status == ST_HALTED)
        else $error("line end while halted did not report halted");

    // Only an ok record carries a date key
    a_key_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_REC_OK |-> o_date_key == 27'd0)
        else $error("date key on a non-ok result");

    // Header, halted and ok results carry no column
    a_col_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_REC_OK || o_status == ST_HDR_OK
                    || o_status == ST_HDR_BAD || o_status == ST_HALTED)
        |-> o_column == 11'd0)
        else $error("column set on a result without an error column");

endmodule

/* bench/dated_value_record_checker_tb.sv */
`timescale 1ns / 1ps

module dated_value_record_checker_tb;
    import dvrc_pkg::*;

    // One input transfer: a character or an end of line marker
    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
    } t_item;

    // One line result as the block should report it
    typedef struct packed {
        t_status     status;
        logic [10:0] column;
        logic [23:0] line_no;
        logic [26:0] key;
    } t_line_result;

    // Kinds of faulty data line used to end the clean part of the stream
    typedef enum int {
        BRK_LENGTH, BRK_DATE_CHAR, BRK_SEPARATOR, BRK_VALUE_CHAR, BRK_TWO_DOTS,
        BRK_NO_DIGIT, BRK_LATE_SIGN, BRK_MONTH, BRK_DAY, BRK_NEGATIVE, BRK_LONG_BAD
    } t_break;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          CALM_TAIL      = 150;
    localparam int          DRAIN_CYCLES   = 10;
    localparam logic [10:0] COL_SAT        = 11'h7FF;
    localparam logic [10:0] COL_MONTH      = 11'd6;
    localparam logic [10:0] COL_DAY        = 11'd9;
    localparam logic [10:0] COL_VALUE      = 11'd12;
    localparam logic [10:0] COL_SEP        = 11'd11;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_ch = 8'h00;
    logic        i_end_of_line = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_status;
    logic [10:0] o_column;
    logic [23:0] o_line_number;
    logic [26:0] o_date_key;

    t_item        char_stream[$];
    logic [7:0]   line_buf[$];
    t_line_result line_results_due[$];

    int  items_total = 0;
    int  items_accepted = 0;
    int  results_taken = 0;
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    bit  in_taken = 1'b0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    // Line checker model state
    logic [23:0] lines_seen = '0;
    logic [10:0] pos = '0;
    logic [13:0] yr = '0;
    logic [6:0]  mo = '0;
    logic [6:0]  dy = '0;
    t_status     err_code = ST_REC_OK;
    logic [10:0] err_col = '0;
    logic        seen_dot = 1'b0;
    logic        seen_digit = 1'b0;
    logic        seen_minus = 1'b0;
    logic        seen_nonzero = 1'b0;
    logic        hdr_ok = 1'b1;
    logic        stopped = 1'b0;

    dated_value_record_checker #(
        .COLUMN_BITS     (11),
        .LINE_COUNT_BITS (24)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_ch          (i_ch),
        .i_end_of_line (i_end_of_line),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_column      (o_column),
        .o_line_number (o_line_number),
        .o_date_key    (o_date_key)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Gregorian month length
    function automatic int month_days(input int m, input int y);
        if (m == 2) begin
            return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
        end
        if (m == 4 || m == 6 || m == 9 || m == 11) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic bit is_digit(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("MISMATCH @%0t: %s", $realtime, msg);
        end
    endtask

    // Model: advance line state by one accepted transfer, queue a result on line end
    task automatic predict_item(input logic [7:0] c, input logic eol);
        t_line_result r;
        bit           was_hdr;
        if (!eol) begin
            if (stopped) begin
                return;
            end
            if (lines_seen == '0) begin
                if (pos >= HDR_LEN || hdr_char(pos[4:0]) != c) begin
                    hdr_ok = 1'b0;
                end
            end else if (err_code == ST_REC_OK) begin
                if (pos < 10) begin
                    if (pos == 4 || pos == 7) begin
                        if (c != CH_DASH) begin
                            err_code = ST_DATE_FMT;
                            err_col  = pos + 11'd1;
                        end
                    end else if (!is_digit(c)) begin
                        err_code = ST_DATE_FMT;
                        err_col  = pos + 11'd1;
                    end else if (pos < 4) begin
                        yr = 14'(yr * 10 + (c - CH_ZERO));
                    end else if (pos < 7) begin
                        mo = 7'(mo * 10 + (c - CH_ZERO));
                    end else begin
                        dy = 7'(dy * 10 + (c - CH_ZERO));
                    end
                end else if (pos == 10) begin
                    if (c != CH_COMMA) begin
                        err_code = ST_SEP;
                        err_col  = COL_SEP;
                    end
                end else if (pos == VAL_START && (c == CH_PLUS || c == CH_DASH)) begin
                    if (c == CH_DASH) begin
                        seen_minus = 1'b1;
                    end
                end else if (c == CH_DOT) begin
                    if (seen_dot) begin
                        err_code = ST_VALUE;
                        err_col  = (pos >= COL_SAT) ? COL_SAT : pos + 11'd1;
                    end
                    seen_dot = 1'b1;
                end else if (is_digit(c)) begin
                    seen_digit = 1'b1;
                    if (c != CH_ZERO) begin
                        seen_nonzero = 1'b1;
                    end
                end else begin
                    err_code = ST_VALUE;
                    err_col  = (pos >= COL_SAT) ? COL_SAT : pos + 11'd1;
                end
            end
            if (pos < COL_SAT) begin
                pos++;
            end
            return;
        end

        // Line end: classify the line in check order
        was_hdr = (lines_seen == '0);
        if (lines_seen != '1) begin
            lines_seen++;
        end
        r.status  = ST_REC_OK;
        r.column  = '0;
        r.line_no = lines_seen;
        r.key     = '0;
        if (stopped) begin
            r.status = ST_HALTED;
        end else if (was_hdr) begin
            r.status = (hdr_ok && pos == HDR_LEN) ? ST_HDR_OK : ST_HDR_BAD;
        end else if (pos < MIN_LEN) begin
            r.status = ST_LENGTH;
            r.column = pos;
        end else if (err_code != ST_REC_OK) begin
            r.status = err_code;
            r.column = err_col;
        end else if (!seen_digit) begin
            r.status = ST_VALUE;
            r.column = COL_VALUE;
        end else if (mo == 0 || mo > 12) begin
            r.status = ST_MONTH;
            r.column = COL_MONTH;
        end else if (dy == 0 || dy > month_days(mo, yr)) begin
            r.status = ST_DAY;
            r.column = COL_DAY;
        end else if (seen_minus && seen_nonzero) begin
            r.status = ST_NEGATIVE;
            r.column = COL_VALUE;
        end else begin
            r.key = 27'(yr * 10000 + mo * 100 + dy);
        end
        if (r.status >= ST_HDR_BAD) begin
            stopped = 1'b1;
        end
        line_results_due.push_back(r);

        // Fresh line
        pos = '0;
        yr = '0;
        mo = '0;
        dy = '0;
        err_code = ST_REC_OK;
        err_col = '0;
        seen_dot = 1'b0;
        seen_digit = 1'b0;
        seen_minus = 1'b0;
        seen_nonzero = 1'b0;
        hdr_ok = 1'b1;
    endtask

    // ---- stream building ----

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            line_buf.push_back(s[i]);
        end
    endtask

    task automatic push_digits(input int n);
        for (int i = 0; i < n; i++) begin
            line_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
        end
    endtask

    // Move the scratch line into the stream, closed by a line end
    task automatic emit_line();
        foreach (line_buf[i]) begin
            char_stream.push_back(t_item'{ch: line_buf[i], eol: 1'b0});
        end
        char_stream.push_back(t_item'{ch: 8'($urandom_range(0, 255)), eol: 1'b1});
        line_buf.delete();
    endtask

    task automatic build_date(input int y, input int m, input int d);
        push_text($sformatf("%04d-%02d-%02d,", y, m, d));
    endtask

    // A valid date, leaning on month ends and February in century years
    task automatic pick_date(output int y, output int m, output int d);
        case ($urandom_range(0, 3))
            0: begin
                case ($urandom_range(0, 5))
                    0: y = 0;
                    1: y = 1900;
                    2: y = 2000;
                    3: y = 2100;
                    4: y = 4 * $urandom_range(0, 2499);
                    default: y = $urandom_range(0, 9999);
                endcase
                m = 2;
                d = month_days(m, y);
            end
            1: begin
                y = $urandom_range(0, 9999);
                m = $urandom_range(1, 12);
                d = month_days(m, y);
            end
            default: begin
                y = $urandom_range(0, 9999);
                m = $urandom_range(1, 12);
                d = $urandom_range(1, month_days(m, y));
            end
        endcase
    endtask

    // Value: optional sign, 1..8 digits, maybe one dot; minus only with zeros unless negative
    task automatic build_value(input bit negative);
        int         sign_pick;
        int         ndig;
        int         dot_at;
        logic [7:0] dgt;
        sign_pick = $urandom_range(0, 3);
        ndig = $urandom_range(1, 8);
        dot_at = ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, ndig);
        if (negative || sign_pick == 1) begin
            line_buf.push_back(CH_DASH);
        end else if (sign_pick == 0) begin
            line_buf.push_back(CH_PLUS);
        end
        for (int i = 0; i < ndig; i++) begin
            if (i == dot_at) begin
                line_buf.push_back(CH_DOT);
            end
            if (negative && i == 0) begin
                dgt = 8'(CH_ZERO + $urandom_range(1, 9));
            end else if (!negative && sign_pick == 1) begin
                dgt = CH_ZERO;
            end else begin
                dgt = 8'(CH_ZERO + $urandom_range(0, 9));
            end
            line_buf.push_back(dgt);
        end
        if (dot_at == ndig) begin
            line_buf.push_back(CH_DOT);
        end
    endtask

    task automatic build_record();
        int y, m, d;
        pick_date(y, m, d);
        build_date(y, m, d);
        build_value(1'b0);
    endtask

    // One faulty data line of a random kind
    task automatic build_broken_line();
        t_break     kind;
        int         y, m, d;
        int         p;
        int         n;
        logic [7:0] c;
        kind = t_break'($urandom_range(0, BRK_LONG_BAD));
        case (kind)
            BRK_LENGTH: begin
                build_record();
                n = $urandom_range(0, MIN_LEN - 1);
                while (line_buf.size() > n) begin
                    void'(line_buf.pop_back());
                end
            end
            BRK_DATE_CHAR: begin
                build_record();
                p = $urandom_range(0, 9);
                if (p == 4 || p == 7) begin
                    do c = 8'($urandom_range(0, 255)); while (c == CH_DASH);
                end else begin
                    do c = 8'($urandom_range(0, 255)); while (is_digit(c));
                end
                line_buf[p] = c;
            end
            BRK_SEPARATOR: begin
                build_record();
                do c = 8'($urandom_range(0, 255)); while (c == CH_COMMA);
                line_buf[10] = c;
            end
            BRK_VALUE_CHAR: begin
                build_record();
                p = $urandom_range(VAL_START, line_buf.size() - 1);
                do begin
                    c = 8'($urandom_range(0, 255));
                end while (is_digit(c) || c == CH_DOT ||
                           (p == VAL_START && (c == CH_PLUS || c == CH_DASH)));
                line_buf[p] = c;
            end
            BRK_TWO_DOTS: begin
                pick_date(y, m, d);
                build_date(y, m, d);
                push_digits($urandom_range(0, 3));
                line_buf.push_back(CH_DOT);
                push_digits($urandom_range(0, 3));
                line_buf.push_back(CH_DOT);
                push_digits($urandom_range(0, 3));
            end
            BRK_NO_DIGIT: begin
                pick_date(y, m, d);
                build_date(y, m, d);
                case ($urandom_range(0, 3))
                    0: line_buf.push_back(CH_PLUS);
                    1: line_buf.push_back(CH_DASH);
                    2: line_buf.push_back(CH_DOT);
                    default: begin
                        line_buf.push_back(CH_DASH);
                        line_buf.push_back(CH_DOT);
                    end
                endcase
            end
            BRK_LATE_SIGN: begin
                pick_date(y, m, d);
                build_date(y, m, d);
                push_digits($urandom_range(1, 3));
                line_buf.push_back(($urandom_range(0, 1) == 0) ? CH_PLUS : CH_DASH);
                push_digits($urandom_range(0, 3));
            end
            BRK_MONTH: begin
                m = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 99);
                build_date($urandom_range(0, 9999), m, $urandom_range(1, 28));
                build_value(1'b0);
            end
            BRK_DAY: begin
                y = ($urandom_range(0, 1) == 0) ? 1900 : $urandom_range(0, 9999);
                m = $urandom_range(1, 12);
                d = ($urandom_range(0, 3) == 0) ? 0 :
                    $urandom_range(month_days(m, y) + 1, month_days(m, y) + 2);
                if ($urandom_range(0, 3) == 0) begin
                    d = $urandom_range(32, 99);
                end
                build_date(y, m, d);
                build_value(1'b0);
            end
            BRK_NEGATIVE: begin
                pick_date(y, m, d);
                build_date(y, m, d);
                build_value(1'b1);
            end
            default: begin
                // Fault deep inside a long value
                pick_date(y, m, d);
                build_date(y, m, d);
                push_digits($urandom_range(40, 80));
                do begin
                    c = 8'($urandom_range(0, 255));
                end while (is_digit(c) || c == CH_DOT);
                line_buf.push_back(c);
                push_digits(3);
            end
        endcase
        emit_line();
    endtask

    // ---- stimulus and end of run ----
    initial begin
        int         mark;
        int         idx;
        logic [7:0] c;

        // Header, occasionally malformed (then every later line is halted)
        for (int i = 0; i < HDR_LEN; i++) begin
            line_buf.push_back(HDR_TEXT[i]);
        end
        if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 2))
                0: begin
                    idx = $urandom_range(0, HDR_LEN - 1);
                    do c = 8'($urandom_range(0, 255)); while (c == line_buf[idx]);
                    line_buf[idx] = c;
                end
                1: begin
                    idx = $urandom_range(0, HDR_LEN - 1);
                    while (line_buf.size() > idx) begin
                        void'(line_buf.pop_back());
                    end
                end
                default: line_buf.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        emit_line();

        // Directed records: extreme dates, leap rules, signs, dot placement, minus zero
        push_text("0000-02-29,0");          emit_line();
        push_text("9999-12-31,99999999.9"); emit_line();
        push_text("1900-02-28,-0");         emit_line();
        push_text("2000-02-29,+1.5");       emit_line();
        push_text("2024-01-31,.5");         emit_line();
        push_text("2023-04-30,7.");         emit_line();
        push_text("2100-02-28,-0.000");     emit_line();
        push_text("2023-11-30,+0");         emit_line();
        push_text("0001-01-01,1234567890"); emit_line();

        // One record with a long value
        build_date(2020, 6, 15);
        push_digits(40);
        line_buf.push_back(CH_DOT);
        push_digits(40);
        emit_line();

        // Random clean records
        mark = char_stream.size();
        while (char_stream.size() < mark + 600) begin
            build_record();
            emit_line();
        end

        // First fault, then lines that must all come back halted
        build_broken_line();
        for (int k = 0; k < 4; k++) begin
            repeat ($urandom_range(0, 25)) begin
                line_buf.push_back(8'($urandom_range(0, 255)));
            end
            emit_line();
        end
        build_record();
        emit_line();
        items_total = char_stream.size();

        // Reset
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every transfer and every result, then let the pipe drain
        while (items_accepted < items_total || line_results_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_count == 0 && line_results_due.size() == 0) begin
            $display("dated_value_record_checker_tb OK");
        end else begin
            $display("dated_value_record_checker_tb NOT OK");
        end
        $finish;
    end

    // Driver: hold the item until transferred, random idle bursts except in the tail
    always @(negedge i_clk) begin : drive_input
        t_item nxt;
        if (i_rst_n && (!i_valid || in_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (char_stream.size() != 0) begin
                if (char_stream.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 16) - 1;
                    i_valid <= 1'b0;
                end else begin
                    nxt = char_stream.pop_front();
                    i_valid <= 1'b1;
                    i_ch <= nxt.ch;
                    i_end_of_line <= nxt.eol;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: one long hold-off early on, random stall bursts except in the tail
    always @(negedge i_clk) begin : drive_stall
        if (i_rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && results_taken >= 3) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (char_stream.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Monitor: check result transfers, feed input transfers to the model, watchdog
    always @(posedge i_clk) begin : watch
        t_line_result want;
        bit           out_taken;
        if (i_rst_n) begin
            in_taken  = i_valid && !o_stall;
            out_taken = o_valid && !i_stall;

            if (out_taken) begin
                results_taken++;
                if (line_results_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result: status %0d line %0d",
                                              o_status, o_line_number));
                end else begin
                    want = line_results_due.pop_front();
                    if (o_status !== want.status) begin
                        report_mismatch($sformatf("line %0d status %0d, want %0d",
                                                  want.line_no, o_status, want.status));
                    end
                    if (o_column !== want.column) begin
                        report_mismatch($sformatf("line %0d column %0d, want %0d",
                                                  want.line_no, o_column, want.column));
                    end
                    if (o_line_number !== want.line_no) begin
                        report_mismatch($sformatf("line number %0d, want %0d",
                                                  o_line_number, want.line_no));
                    end
                    if (o_date_key !== want.key) begin
                        report_mismatch($sformatf("line %0d date key %0d, want %0d",
                                                  want.line_no, o_date_key, want.key));
                    end
                end
            end

            if (in_taken) begin
                items_accepted++;
                predict_item(i_ch, i_end_of_line);
            end

            if (in_taken || out_taken) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("dated_value_record_checker_tb NOT OK");
                $finish;
            end
        end
    end

endmodule

/* sim.f */
hdl/dvrc_pkg.sv
hdl/dated_value_record_checker.sv
bench/dated_value_record_checker_tb.sv
